// File: rtl/qrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_pkg: shared widths, codes and types of the quadratic root solver
// Widths follow from the data word and the fraction bits; everything below
// is derived from DW and FB.
// ----------------------------------------------------------------------------
package qrs_pkg;

	// data word and fraction bits (Q16.16)
	localparam int DW     = 32;
	localparam int FB     = 16;
	// product of two magnitudes
	localparam int PW     = 2 * DW;
	// discriminant b^2 + 4|ac| at full width
	localparam int DISCW  = PW + 3;
	// square root bits, padded radicand and partial remainder
	localparam int SQW    = (DISCW + 1) / 2;
	localparam int SQDW   = 2 * SQW;
	localparam int SQRW   = SQW + 3;
	// numerator magnitude before and after the fraction shift
	localparam int NMW    = SQW + 1;
	localparam int NW     = NMW + FB;
	// divisor 2|a| and divider remainder
	localparam int DENW   = DW + 1;
	localparam int DRW    = DENW + 1;
	// configuration register index
	localparam int CFG_IW = 1;

	localparam logic [CFG_IW-1:0] REG_COEF_A = 1'b0;
	localparam logic [CFG_IW-1:0] REG_COEF_B = 1'b1;

	localparam logic [DW-1:0] COEF_A_RST = DW'(64'd1 << FB);
	localparam logic [DW-1:0] COEF_B_RST = '0;
	localparam logic [DW-1:0] NEG_ONE    = DW'(64'd0) - DW'(64'd1 << FB);

	typedef enum logic [1:0] {
		ST_REAL  = 2'd0,
		ST_NONE  = 2'd1,
		ST_AZERO = 2'd2,
		ST_SAT   = 2'd3
	} status_t;

	// values that ride along the square root pipeline
	typedef struct packed {
		logic            azero;
		logic            dneg;
		logic            an;
		logic            bpos;
		logic [DW-1:0]   bm;
		logic [DENW-1:0] den;
	} side_t;

	// values that ride along a divider
	typedef struct packed {
		logic azero;
		logic dneg;
		logic neg;
	} tag_t;

endpackage
`default_nettype wire

// File: rtl/qrs_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_if: valid/ready channels of the quadratic root solver
// One interface for the coefficient input, one for the root output.
// ----------------------------------------------------------------------------
interface qrs_in_if;
	logic                     valid;
	logic                     ready;
	logic [qrs_pkg::DW-1:0]   coef_c;

	modport source (output valid, output coef_c, input ready);
	modport sink   (input valid, input coef_c, output ready);
endinterface

interface qrs_out_if;
	logic                     valid;
	logic                     ready;
	logic [qrs_pkg::DW-1:0]   root_plus;
	logic [qrs_pkg::DW-1:0]   root_minus;
	logic [1:0]               status;

	modport source (output valid, output root_plus, output root_minus, output status,
		input ready);
	modport sink   (input valid, input root_plus, input root_minus, input status,
		output ready);
endinterface
`default_nettype wire

// File: rtl/qrs_disc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_disc: discriminant front end
// Three stages: sign/magnitude split, the two products, then b^2 -/+ 4ac.
// ----------------------------------------------------------------------------
module qrs_disc (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  wire logic [qrs_pkg::DW-1:0]      coef_a,
	input  wire logic [qrs_pkg::DW-1:0]      coef_b,
	input  wire logic [qrs_pkg::DW-1:0]      coef_c,
	output logic                             out_valid,
	output logic [qrs_pkg::DISCW-1:0]        disc,
	output qrs_pkg::side_t                   side
);

	localparam int DW    = qrs_pkg::DW;
	localparam int PW    = qrs_pkg::PW;
	localparam int DISCW = qrs_pkg::DISCW;

	logic          an, bn, cn;
	logic [DW-1:0] am, bm, cm;

	logic          v_s1, an_s1, bn_s1, cn_s1;
	logic [DW-1:0] am_s1, bm_s1, cm_s1;

	logic          v_s2, an_s2, add_s2, azero_s2, bpos_s2;
	logic [PW-1:0] b2_s2, ac_s2;
	logic [DW-1:0] am_s2, bm_s2;

	logic             v_s3;
	logic [DISCW-1:0] disc_s3;
	qrs_pkg::side_t   side_s3;

	logic [PW+1:0]    ac4;
	logic [DISCW-1:0] sum, diff;
	logic             ge;

	// split each coefficient into sign and magnitude
	always_comb begin
		an = coef_a[DW-1];
		bn = coef_b[DW-1];
		cn = coef_c[DW-1];
		am = an ? (DW'(0) - coef_a) : coef_a;
		bm = bn ? (DW'(0) - coef_b) : coef_b;
		cm = cn ? (DW'(0) - coef_c) : coef_c;
	end

	// form 4|ac| and both candidate discriminants
	always_comb begin
		ac4  = {ac_s2, 2'b00};
		sum  = DISCW'(b2_s2) + DISCW'(ac4);
		diff = DISCW'(b2_s2) - DISCW'(ac4);
		ge   = {2'b00, b2_s2} >= ac4;
	end

	// advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// advance the payload
	always_ff @(posedge clk) begin
		if (en) begin
			an_s1    <= an;
			bn_s1    <= bn;
			cn_s1    <= cn;
			am_s1    <= am;
			bm_s1    <= bm;
			cm_s1    <= cm;

			b2_s2    <= PW'(bm_s1) * PW'(bm_s1);
			ac_s2    <= PW'(am_s1) * PW'(cm_s1);
			an_s2    <= an_s1;
			add_s2   <= (an_s1 != cn_s1) && (cm_s1 != '0);
			azero_s2 <= am_s1 == '0;
			bpos_s2  <= !bn_s1 && (bm_s1 != '0);
			am_s2    <= am_s1;
			bm_s2    <= bm_s1;

			disc_s3       <= add_s2 ? sum : diff;
			side_s3.azero <= azero_s2;
			side_s3.dneg  <= !add_s2 && !ge;
			side_s3.an    <= an_s2;
			side_s3.bpos  <= bpos_s2;
			side_s3.bm    <= bm_s2;
			side_s3.den   <= {am_s2, 1'b0};
		end
	end

	assign out_valid = v_s3;
	assign disc      = disc_s3;
	assign side      = side_s3;

endmodule
`default_nettype wire

// File: rtl/qrs_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_sqrt: pipelined integer square root
// One root bit per stage, rounded down, restoring digit recurrence.
// ----------------------------------------------------------------------------
module qrs_sqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  wire logic [qrs_pkg::DISCW-1:0]   disc,
	input  qrs_pkg::side_t                   side_in,
	output logic                             out_valid,
	output logic [qrs_pkg::SQW-1:0]          root,
	output qrs_pkg::side_t                   side_out
);

	localparam int SQW   = qrs_pkg::SQW;
	localparam int SQDW  = qrs_pkg::SQDW;
	localparam int SQRW  = qrs_pkg::SQRW;

	logic [SQDW-1:0] rad_s  [0:SQW];
	logic [SQRW-1:0] rem_s  [0:SQW];
	logic [SQW-1:0]  root_s [0:SQW];
	qrs_pkg::side_t  side_s [0:SQW];
	logic            v_s    [0:SQW];

	// feed the first stage straight from the input
	assign rad_s[0]  = SQDW'(disc);
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = side_in;
	assign v_s[0]    = in_valid;

	for (genvar k = 0; k < SQW; k++) begin : g_stage
		logic [SQRW-1:0] rem_sh, trial;
		logic            take;

		// bring down two radicand bits and try the next root bit
		always_comb begin
			rem_sh = {rem_s[k][SQRW-3:0], rad_s[k][SQDW-1 -: 2]};
			trial  = {{(SQRW-SQW-2){1'b0}}, root_s[k], 2'b01};
			take   = rem_sh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= {rad_s[k][SQDW-3:0], 2'b00};
				rem_s[k+1]  <= take ? (rem_sh - trial) : rem_sh;
				root_s[k+1] <= {root_s[k][SQW-2:0], take};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[SQW];
	assign root      = root_s[SQW];
	assign side_out  = side_s[SQW];

endmodule
`default_nettype wire

// File: rtl/qrs_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_div: pipelined unsigned divider
// One quotient bit per stage, restoring long division, truncating.
// ----------------------------------------------------------------------------
module qrs_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  wire logic [qrs_pkg::NW-1:0]      num,
	input  wire logic [qrs_pkg::DENW-1:0]    den,
	input  qrs_pkg::tag_t                    tag_in,
	output logic                             out_valid,
	output logic [qrs_pkg::NW-1:0]           quot,
	output qrs_pkg::tag_t                    tag_out
);

	localparam int NW   = qrs_pkg::NW;
	localparam int DENW = qrs_pkg::DENW;
	localparam int DRW  = qrs_pkg::DRW;

	logic [NW-1:0]   num_s [0:NW];
	logic [DENW-1:0] den_s [0:NW];
	logic [DRW-1:0]  rem_s [0:NW];
	logic [NW-1:0]   q_s   [0:NW];
	qrs_pkg::tag_t   tag_s [0:NW];
	logic            v_s   [0:NW];

	assign num_s[0] = num;
	assign den_s[0] = den;
	assign rem_s[0] = '0;
	assign q_s[0]   = '0;
	assign tag_s[0] = tag_in;
	assign v_s[0]   = in_valid;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DRW-1:0] rem_sh;
		logic           take;

		// bring down one numerator bit and compare with the divisor
		always_comb begin
			rem_sh = {rem_s[k][DRW-2:0], num_s[k][NW-1]};
			take   = rem_sh >= {1'b0, den_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k+1] <= {num_s[k][NW-2:0], 1'b0};
				den_s[k+1] <= den_s[k];
				rem_s[k+1] <= take ? (rem_sh - {1'b0, den_s[k]}) : rem_sh;
				q_s[k+1]   <= {q_s[k][NW-2:0], take};
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_valid = v_s[NW];
	assign quot      = q_s[NW];
	assign tag_out   = tag_s[NW];

endmodule
`default_nettype wire

// File: rtl/quadratic_root_solver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_root_solver: real roots of a*x^2 + b*x + c = 0, signed Q16.16
// Coefficients a and b sit in configuration registers; c comes per item.
// ----------------------------------------------------------------------------
// Usage:
//   Write coef_a (index 0) and coef_b (index 1) through cfg_we / cfg_index /
//   cfg_data while no transaction is in flight. Each transaction on coef_in
//   carries c and yields exactly one transaction on root_out with
//   root_plus, root_minus and a status code (real, none, a is zero,
//   saturated).
//   Throughput is one transaction per cycle while root_out does not stall.
//   A transaction passes 3 discriminant stages, 34 square root stages (one
//   root bit each), 1 numerator stage, 51 divider stages (one quotient bit
//   each) and the output register before its result is offered.
//   The whole pipeline advances as one; when root_out stalls with a result
//   waiting, every stage holds and coef_in.ready drops, so nothing is lost
//   or repeated.
//   Reset clears all valid bits and loads a = 1.0, b = 0.
// ----------------------------------------------------------------------------
module quadratic_root_solver (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [qrs_pkg::CFG_IW-1:0]    cfg_index,
	input  wire logic [qrs_pkg::DW-1:0]        cfg_data,
	qrs_in_if.sink                             coef_in,
	qrs_out_if.source                          root_out
);

	localparam int DW   = qrs_pkg::DW;
	localparam int FB   = qrs_pkg::FB;
	localparam int SQW  = qrs_pkg::SQW;
	localparam int NMW  = qrs_pkg::NMW;
	localparam int NW   = qrs_pkg::NW;
	localparam int DISCW = qrs_pkg::DISCW;

	logic [DW-1:0] coef_a_q, coef_b_q;
	logic          en;

	logic             d_valid;
	logic [DISCW-1:0] d_disc;
	qrs_pkg::side_t   d_side;

	logic             r_valid;
	logic [SQW-1:0]   r_root;
	qrs_pkg::side_t   r_side;

	logic             v_s4;
	logic [NW-1:0]    nump_s4, numm_s4;
	logic [qrs_pkg::DENW-1:0] den_s4;
	qrs_pkg::tag_t    tagp_s4, tagm_s4;

	logic [NMW-1:0]   bm_x, s_x, add_m, bms, sbm;
	logic             bge, pn, mn;
	logic [NMW-1:0]   pm, mm;

	logic             p_valid, m_valid;
	logic [NW-1:0]    qp, qm;
	qrs_pkg::tag_t    tp, tm;

	logic [NW-1:0]    limp, limm;
	logic             satp, satm;
	logic [DW-1:0]    valp, valm;

	logic               out_valid_q;
	logic [DW-1:0]      root_plus_q, root_minus_q;
	qrs_pkg::status_t   status_q;

	// advance everything together unless a result is stuck at the output
	assign en            = !out_valid_q || root_out.ready;
	assign coef_in.ready = en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= qrs_pkg::COEF_A_RST;
			coef_b_q <= qrs_pkg::COEF_B_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				qrs_pkg::REG_COEF_A: coef_a_q <= cfg_data;
				qrs_pkg::REG_COEF_B: coef_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	qrs_disc u_disc (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (coef_in.valid),
		.coef_a    (coef_a_q),
		.coef_b    (coef_b_q),
		.coef_c    (coef_in.coef_c),
		.out_valid (d_valid),
		.disc      (d_disc),
		.side      (d_side)
	);

	qrs_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (d_valid),
		.disc      (d_disc),
		.side_in   (d_side),
		.out_valid (r_valid),
		.root      (r_root),
		.side_out  (r_side)
	);

	// add -b and +/- sqrt in sign-magnitude form
	always_comb begin
		bm_x  = NMW'(r_side.bm);
		s_x   = NMW'(r_root);
		add_m = bm_x + s_x;
		bms   = bm_x - s_x;
		sbm   = s_x - bm_x;
		bge   = bm_x >= s_x;
		// plus root: -b + s
		if (!r_side.bpos) begin
			pn = 1'b0;
			pm = add_m;
		end else if (bge) begin
			pn = 1'b1;
			pm = bms;
		end else begin
			pn = 1'b0;
			pm = sbm;
		end
		// minus root: -b - s
		if (r_side.bpos) begin
			mn = 1'b1;
			mm = add_m;
		end else if (bge) begin
			mn = 1'b0;
			mm = bms;
		end else begin
			mn = 1'b1;
			mm = sbm;
		end
	end

	// numerator stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= r_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nump_s4       <= {pm, {FB{1'b0}}};
			numm_s4       <= {mm, {FB{1'b0}}};
			den_s4        <= r_side.den;
			tagp_s4.azero <= r_side.azero;
			tagp_s4.dneg  <= r_side.dneg;
			tagp_s4.neg   <= (pm != '0) && (pn != r_side.an);
			tagm_s4.azero <= r_side.azero;
			tagm_s4.dneg  <= r_side.dneg;
			tagm_s4.neg   <= (mm != '0) && (mn != r_side.an);
		end
	end

	qrs_div u_div_plus (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.num       (nump_s4),
		.den       (den_s4),
		.tag_in    (tagp_s4),
		.out_valid (p_valid),
		.quot      (qp),
		.tag_out   (tp)
	);

	qrs_div u_div_minus (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.num       (numm_s4),
		.den       (den_s4),
		.tag_in    (tagm_s4),
		.out_valid (m_valid),
		.quot      (qm),
		.tag_out   (tm)
	);

	// saturate and restore the sign of each quotient
	always_comb begin
		limp = tp.neg ? (NW'(1) << (DW-1)) : ((NW'(1) << (DW-1)) - NW'(1));
		limm = tm.neg ? (NW'(1) << (DW-1)) : ((NW'(1) << (DW-1)) - NW'(1));
		satp = qp > limp;
		satm = qm > limm;
		valp = satp ? limp[DW-1:0] : qp[DW-1:0];
		valm = satm ? limm[DW-1:0] : qm[DW-1:0];
		if (tp.neg) valp = DW'(0) - valp;
		if (tm.neg) valm = DW'(0) - valm;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= p_valid && m_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (tp.azero) begin
				root_plus_q  <= '0;
				root_minus_q <= '0;
				status_q     <= qrs_pkg::ST_AZERO;
			end else if (tp.dneg) begin
				root_plus_q  <= qrs_pkg::NEG_ONE;
				root_minus_q <= qrs_pkg::NEG_ONE;
				status_q     <= qrs_pkg::ST_NONE;
			end else begin
				root_plus_q  <= valp;
				root_minus_q <= valm;
				status_q     <= (satp || satm) ? qrs_pkg::ST_SAT : qrs_pkg::ST_REAL;
			end
		end
	end

	assign root_out.valid      = out_valid_q;
	assign root_out.root_plus  = root_plus_q;
	assign root_out.root_minus = root_minus_q;
	assign root_out.status     = status_q;

	// both dividers run in lock step
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		p_valid == m_valid)
		else $error("divider valid bits differ");

	// a waiting result blocks new input
	a_stall_block: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !root_out.ready) |-> !coef_in.ready)
		else $error("input accepted while output stalled");

	// no real roots gives -1.0 on both outputs
	a_none_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == qrs_pkg::ST_NONE) |->
		(root_plus_q == qrs_pkg::NEG_ONE && root_minus_q == qrs_pkg::NEG_ONE))
		else $error("no-real-roots result is not -1.0");

	// a held result stays valid with its status unchanged under stall
	a_hold_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !root_out.ready) |=> (out_valid_q && $stable(status_q)))
		else $error("stalled result changed");

endmodule
`default_nettype wire

// File: tb/sv/quadratic_root_solver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_tb: self-checking bench for the quadratic root solver
// Sweeps coefficient settings and feeds constant terms in bursts. Each
// transaction is predicted with exact wide arithmetic and checked field by
// field against the root output, under random back-pressure.
// ----------------------------------------------------------------------------
module quadratic_root_solver_tb;

	typedef struct {
		logic [qrs_pkg::DW-1:0] root_plus;
		logic [qrs_pkg::DW-1:0] root_minus;
		qrs_pkg::status_t       status;
	} roots_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [qrs_pkg::CFG_IW-1:0] cfg_index = qrs_pkg::REG_COEF_A;
	logic [qrs_pkg::DW-1:0]     cfg_data = '0;

	qrs_in_if  coef_in ();
	qrs_out_if root_out ();

	quadratic_root_solver DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef_in   (coef_in),
		.root_out  (root_out)
	);

	// bench copy of the coefficient registers
	logic [qrs_pkg::DW-1:0] a_reg = qrs_pkg::COEF_A_RST;
	logic [qrs_pkg::DW-1:0] b_reg = qrs_pkg::COEF_B_RST;

	logic [qrs_pkg::DW-1:0] pending_c[$];
	roots_t        expected_roots[$];
	int            errors = 0;
	int            accepted_in = 0;
	int            checked_out = 0;
	int            cnt_status[4] = '{0, 0, 0, 0};

	initial begin
		coef_in.valid  = 1'b0;
		coef_in.coef_c = '0;
		root_out.ready = 1'b0;
	end

	always #5 clk = ~clk;

	// floor square root of a non-negative discriminant
	function automatic logic [39:0] floor_sqrt(input logic [79:0] d);
		logic [39:0] r;
		logic [39:0] t;
		logic [79:0] sq;
		r = '0;
		for (int i = 39; i >= 0; i--) begin
			t = r | (40'd1 << i);
			sq = {40'd0, t} * {40'd0, t};
			if (sq <= d)
				r = t;
		end
		return r;
	endfunction

	// divide a numerator by 2a toward zero and saturate to the data word
	function automatic logic [qrs_pkg::DW-1:0] scaled_quotient(
		input logic signed [79:0] num, input logic signed [79:0] den, inout logic sat);
		logic signed [79:0] q;
		q = (num <<< qrs_pkg::FB) / den;
		if (q > 80'sd2147483647) begin
			sat = 1'b1;
			return 32'h7fff_ffff;
		end
		if (q < -80'sd2147483648) begin
			sat = 1'b1;
			return 32'h8000_0000;
		end
		return q[qrs_pkg::DW-1:0];
	endfunction

	function automatic roots_t solve_roots(input logic [qrs_pkg::DW-1:0] a,
		input logic [qrs_pkg::DW-1:0] b, input logic [qrs_pkg::DW-1:0] c);
		roots_t r;
		logic signed [79:0] sa, sb, sc, disc, s;
		logic sat;
		sa = {{48{a[qrs_pkg::DW-1]}}, a};
		sb = {{48{b[qrs_pkg::DW-1]}}, b};
		sc = {{48{c[qrs_pkg::DW-1]}}, c};
		sat = 1'b0;
		if (a == '0) begin
			r.root_plus = '0;
			r.root_minus = '0;
			r.status = qrs_pkg::ST_AZERO;
			return r;
		end
		disc = sb * sb - 80'sd4 * sa * sc;
		if (disc < 0) begin
			r.root_plus = qrs_pkg::NEG_ONE;
			r.root_minus = qrs_pkg::NEG_ONE;
			r.status = qrs_pkg::ST_NONE;
			return r;
		end
		s = {40'd0, floor_sqrt(disc)};
		r.root_plus = scaled_quotient(-sb + s, 80'sd2 * sa, sat);
		r.root_minus = scaled_quotient(-sb - s, 80'sd2 * sa, sat);
		r.status = sat ? qrs_pkg::ST_SAT : qrs_pkg::ST_REAL;
		return r;
	endfunction

	// driver: bursts of transactions with random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		logic                   nxt_valid;
		logic [qrs_pkg::DW-1:0] nxt_c;
		if (!arst_n) begin
			coef_in.valid <= 1'b0;
		end else begin
			nxt_valid = coef_in.valid;
			nxt_c = coef_in.coef_c;
			if (coef_in.valid && coef_in.ready) begin
				expected_roots.push_back(solve_roots(a_reg, b_reg, coef_in.coef_c));
				accepted_in++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_c.size() > 0) begin
					nxt_c = pending_c.pop_front();
					nxt_valid = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(40, 1);
						gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 0);
					end
				end
			end
			coef_in.valid <= nxt_valid;
			coef_in.coef_c <= nxt_c;
		end
	end

	// receiver: changing stall pattern plus one long hold-off to fill the pipe
	int  mode_left = 0;
	int  rx_mode = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		logic nxt_ready;
		if (!arst_n) begin
			root_out.ready <= 1'b0;
		end else begin
			if (!hold_done && accepted_in >= 300) begin
				hold_done = 1'b1;
				hold_left = 600;
			end
			if (mode_left == 0) begin
				rx_mode = $urandom_range(2, 0);
				mode_left = $urandom_range(120, 10);
			end else begin
				mode_left--;
			end
			case (rx_mode)
				0: nxt_ready = 1'b1;
				1: nxt_ready = 1'($urandom_range(1, 0));
				default: nxt_ready = ($urandom_range(4, 0) == 0);
			endcase
			if (hold_left > 0) begin
				hold_left--;
				nxt_ready = 1'b0;
			end
			root_out.ready <= nxt_ready;
		end
	end

	// monitor: compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		roots_t e;
		if (arst_n && root_out.valid && root_out.ready) begin
			if (expected_roots.size() == 0) begin
				$error("result transaction with no prediction pending");
				errors++;
			end else begin
				e = expected_roots.pop_front();
				checked_out++;
				cnt_status[e.status]++;
				if (root_out.root_plus !== e.root_plus) begin
					$error("root_plus expected %h actual %h", e.root_plus, root_out.root_plus);
					errors++;
				end
				if (root_out.root_minus !== e.root_minus) begin
					$error("root_minus expected %h actual %h", e.root_minus,
						root_out.root_minus);
					errors++;
				end
				if (root_out.status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, root_out.status);
					errors++;
				end
			end
		end
	end

	task automatic write_coefs(input logic [qrs_pkg::DW-1:0] a,
		input logic [qrs_pkg::DW-1:0] b);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= qrs_pkg::REG_COEF_A;
		cfg_data <= a;
		@(posedge clk);
		cfg_index <= qrs_pkg::REG_COEF_B;
		cfg_data <= b;
		@(posedge clk);
		cfg_we <= 1'b0;
		a_reg = a;
		b_reg = b;
	endtask

	// wait on the falling edge so the driver's updates have settled
	task automatic drain;
		do @(negedge clk);
		while (pending_c.size() != 0 || coef_in.valid || expected_roots.size() != 0);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [qrs_pkg::DW-1:0] pick_word();
		case ($urandom_range(5, 0))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return qrs_pkg::DW'($signed($urandom_range(262144, 0)) - 131072);
			3: return qrs_pkg::DW'($signed($urandom_range(4096, 0)) - 2048);
			default: return $urandom;
		endcase
	endfunction

	// directed settings: zero a, extremes, tiny a for saturation
	logic [qrs_pkg::DW-1:0] dir_a[6] = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000,
		32'h0000_0001, 32'hffff_0000, 32'h0002_0000};
	logic [qrs_pkg::DW-1:0] dir_b[6] = '{32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff,
		32'h7fff_ffff, 32'h0003_0000, 32'hfffc_0000};
	logic [qrs_pkg::DW-1:0] dir_c[8] = '{32'h0000_0000, 32'hffff_0000, 32'h0001_0000,
		32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h0002_0000};

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// directed: reset coefficients first, then the fixed settings
		foreach (dir_c[i]) pending_c.push_back(dir_c[i]);
		drain();
		foreach (dir_a[k]) begin
			write_coefs(dir_a[k], dir_b[k]);
			for (int i = 0; i < 3; i++) pending_c.push_back(dir_c[$urandom_range(7, 0)]);
			drain();
		end
		// random phases, each with its own coefficients
		for (int p = 0; p < 12; p++) begin
			write_coefs(pick_word(), pick_word());
			for (int i = 0; i < 100; i++) begin
				if ($urandom_range(3, 0) == 0 && a_reg != '0)
					pending_c.push_back(a_reg[qrs_pkg::DW-1]
						? qrs_pkg::DW'($urandom_range(65536, 0))
						: -qrs_pkg::DW'($urandom_range(65536, 0)));
				else
					pending_c.push_back(pick_word());
			end
			drain();
		end
		$display("covered %0d transactions: %0d real, %0d none, %0d a zero, %0d saturated",
			checked_out, cnt_status[qrs_pkg::ST_REAL], cnt_status[qrs_pkg::ST_NONE],
			cnt_status[qrs_pkg::ST_AZERO], cnt_status[qrs_pkg::ST_SAT]);
		if (errors == 0)
			$display("quadratic_root_solver_tb: PASS");
		else
			$display("quadratic_root_solver_tb: FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("quadratic_root_solver_tb: FAIL");
		$finish;
	end

endmodule
